// ----- hdl/pat_pkg.sv -----
// Package for the peer authorization table: types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pat_pkg;
  localparam int MaxPeersDefault = 8;
  localparam logic [3:0] TopChannel = 4'd14;

  localparam logic [2:0] ACT_OPEN = 3'd0;
  localparam logic [2:0] ACT_APPROVE = 3'd1;
  localparam logic [2:0] ACT_CANCEL = 3'd2;
  localparam logic [2:0] ACT_TICK = 3'd3;
  localparam logic [2:0] ACT_AUTH = 3'd4;
  localparam logic [2:0] ACT_ROTATE = 3'd5;
  localparam logic [2:0] ACT_REVOKE = 3'd6;
  localparam logic [2:0] ACT_FORGET = 3'd7;

  localparam logic [3:0] R_OK = 4'd0;
  localparam logic [3:0] R_STATE = 4'd1;
  localparam logic [3:0] R_PENDING = 4'd2;
  localparam logic [3:0] R_CAND = 4'd3;
  localparam logic [3:0] R_DUPPEER = 4'd4;
  localparam logic [3:0] R_FULL = 4'd5;
  localparam logic [3:0] R_NOAPP = 4'd6;
  localparam logic [3:0] R_CLOCK = 4'd7;
  localparam logic [3:0] R_EXPIRED = 4'd8;
  localparam logic [3:0] R_DUPKEY = 4'd9;
  localparam logic [3:0] R_UNKNOWN = 4'd10;
  localparam logic [3:0] R_REVOKED = 4'd11;
  localparam logic [3:0] R_KEYMIS = 4'd12;
  localparam logic [3:0] R_CHANMIS = 4'd13;
  localparam logic [3:0] R_DENIED = 4'd14;
  localparam logic [3:0] R_STALE = 4'd15;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_GATEWAY = 3'd1;
  localparam logic [2:0] REG_GAUGE = 3'd2;
  localparam logic [2:0] REG_LOCATOR = 3'd3;
  localparam logic [2:0] REG_BRIDGE = 3'd4;
  localparam logic [2:0] REG_VALID = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [31:0] request_tag;
    logic [31:0] peer_id;
    logic [2:0] peer_kind;
    logic [15:0] perm_mask;
    logic [3:0] radio_channel;
    logic [31:0] key_ref;
    logic [31:0] key_epoch;
    logic [3:0] perm_index;
    logic [63:0] time_now;
  } cmd_t;

  typedef struct packed {
    logic [3:0] result_code;
    logic access_ok;
    logic approval_open;
    logic [3:0] stored_count;
    logic [3:0] live_count;
  } rsp_t;

  typedef struct packed {
    logic active;
    logic [1:0] kind;
    logic [15:0] perms;
    logic [3:0] chan;
  } attr_t;

  typedef struct packed {
    logic [31:0] peer_id;
    logic [31:0] key;
    logic [31:0] epoch;
    attr_t attr;
  } entry_t;
endpackage
`default_nettype wire

// ----- hdl/pat_cfg.sv -----
// Configuration register file of the peer authorization table.
// Depends on pat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pat_cfg (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [63:0] cfg_data,
  output logic [63:0] window_length,
  output logic [3:0][15:0] kind_masks,
  output logic [15:0] valid_perm_mask
);
  import pat_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 64'd30000;
      kind_masks <= {16'd40, 16'd16, 16'd12, 16'd3};
      valid_perm_mask <= 16'd63;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: window_length <= cfg_data;
        REG_GATEWAY: kind_masks[0] <= cfg_data[15:0];
        REG_GAUGE: kind_masks[1] <= cfg_data[15:0];
        REG_LOCATOR: kind_masks[2] <= cfg_data[15:0];
        REG_BRIDGE: kind_masks[3] <= cfg_data[15:0];
        REG_VALID: valid_perm_mask <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/pat_engine.sv -----
// Sequencer of the peer authorization table: scans the entry memory one entry
// at a time with a shared compare unit and shifts entries on forget. Uses pat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pat_engine #(
  parameter int MaxPeers = pat_pkg::MaxPeersDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire pat_pkg::cmd_t cmd,
  input wire logic [63:0] window_length,
  input wire logic [3:0][15:0] kind_masks,
  input wire logic [15:0] valid_perm_mask,
  output logic done,
  output pat_pkg::rsp_t rsp
);
  import pat_pkg::*;

  localparam int IW = (MaxPeers > 1) ? $clog2(MaxPeers) : 1;
  localparam int CW = $clog2(MaxPeers + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  cmd_t c;
  entry_t mem [MaxPeers];
  entry_t rd;
  entry_t hit;
  logic [IW-1:0] raddr;
  logic [CW-1:0] idx;
  logic [CW-1:0] at;
  logic found;
  logic key_dup;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] live_total;
  logic approval_flag;
  logic [31:0] pending_request;
  logic [31:0] pending_peer;
  attr_t pending_attrs;
  logic [63:0] opened_time;
  logic [3:0] code;
  logic granted;
  logic we;
  logic [IW-1:0] waddr;
  entry_t wdata;
  logic [31:0] dup_key;
  logic [31:0] dup_except;
  logic [63:0] elapsed;
  logic [15:0] pbit;

  assign busy = (state != S_IDLE);
  assign elapsed = c.time_now - opened_time;
  assign pbit = 16'd1 << c.perm_index;
  assign dup_key = (c.action == ACT_ROTATE) ? c.key_ref : c.key_ref;
  assign dup_except = (c.action == ACT_ROTATE) ? c.peer_id : 32'd0;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      live_total <= '0;
      approval_flag <= 1'b0;
      pending_request <= '0;
      pending_peer <= '0;
      pending_attrs <= '0;
      opened_time <= '0;
      done <= 1'b0;
      raddr <= '0;
      idx <= '0;
      at <= '0;
      found <= 1'b0;
      key_dup <= 1'b0;
      we <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            c <= cmd;
            idx <= '0;
            raddr <= '0;
            found <= 1'b0;
            key_dup <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (idx >= entry_count) state <= S_DECIDE;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (!found && rd.peer_id == c.peer_id) begin
            found <= 1'b1;
            at <= idx;
            hit <= rd;
          end
          if (rd.attr.active && rd.peer_id != dup_except && rd.key == dup_key)
            key_dup <= 1'b1;
          idx <= idx + 1'b1;
          raddr <= IW'(idx + 1'b1);
          state <= S_READ;
        end
        S_DECIDE: begin
          code <= R_OK;
          granted <= 1'b0;
          state <= S_DONE;
          case (c.action)
            ACT_OPEN: begin
              if (approval_flag) code <= R_PENDING;
              else if (c.request_tag == 0 || c.peer_id == 0 || c.peer_kind > 3'd3 ||
                       c.perm_mask == 0 || (c.perm_mask & ~valid_perm_mask) != 0 ||
                       (c.perm_mask & ~kind_masks[c.peer_kind[1:0]]) != 0 ||
                       c.radio_channel == 0 || c.radio_channel > TopChannel)
                code <= R_CAND;
              else if (found) code <= R_DUPPEER;
              else if (entry_count >= CW'(MaxPeers)) code <= R_FULL;
              else begin
                approval_flag <= 1'b1;
                pending_request <= c.request_tag;
                pending_peer <= c.peer_id;
                pending_attrs <= {1'b0, c.peer_kind[1:0], c.perm_mask, c.radio_channel};
                opened_time <= c.time_now;
              end
            end
            ACT_APPROVE: begin
              if (!approval_flag || c.request_tag != pending_request) code <= R_NOAPP;
              else if (c.time_now < opened_time) code <= R_CLOCK;
              else if (elapsed >= window_length) begin
                code <= R_EXPIRED;
                approval_flag <= 1'b0;
                pending_request <= '0;
                pending_peer <= '0;
                pending_attrs <= '0;
                opened_time <= '0;
              end else if (c.key_ref == 0 || c.key_epoch == 0) code <= R_CAND;
              else if (key_dup) code <= R_DUPKEY;
              else if (entry_count >= CW'(MaxPeers)) code <= R_FULL;
              else begin
                we <= 1'b1;
                waddr <= IW'(entry_count);
                wdata <= {pending_peer, c.key_ref, c.key_epoch,
                          pending_attrs | {1'b1, 22'd0}};
                entry_count <= entry_count + 1'b1;
                live_total <= live_total + 1'b1;
                approval_flag <= 1'b0;
                pending_request <= '0;
                pending_peer <= '0;
                pending_attrs <= '0;
                opened_time <= '0;
              end
            end
            ACT_CANCEL: begin
              if (!approval_flag) code <= R_NOAPP;
              else begin
                approval_flag <= 1'b0;
                pending_request <= '0;
                pending_peer <= '0;
                pending_attrs <= '0;
                opened_time <= '0;
              end
            end
            ACT_TICK: begin
              if (approval_flag) begin
                if (c.time_now < opened_time) code <= R_CLOCK;
                else if (elapsed >= window_length) begin
                  code <= R_EXPIRED;
                  approval_flag <= 1'b0;
                  pending_request <= '0;
                  pending_peer <= '0;
                  pending_attrs <= '0;
                  opened_time <= '0;
                end
              end
            end
            ACT_AUTH: begin
              if (!found) code <= R_UNKNOWN;
              else if (!hit.attr.active) code <= R_REVOKED;
              else if (c.key_ref != hit.key) code <= R_KEYMIS;
              else if (c.radio_channel != hit.attr.chan) code <= R_CHANMIS;
              else if ((pbit & valid_perm_mask) == 0 || (pbit & hit.attr.perms) == 0)
                code <= R_DENIED;
              else granted <= 1'b1;
            end
            ACT_ROTATE: begin
              if (!found) code <= R_UNKNOWN;
              else if (!hit.attr.active) code <= R_REVOKED;
              else if (c.key_ref == 0 || c.key_epoch <= hit.epoch) code <= R_STALE;
              else if (key_dup) code <= R_DUPKEY;
              else begin
                we <= 1'b1;
                waddr <= IW'(at);
                wdata <= {hit.peer_id, c.key_ref, c.key_epoch, hit.attr};
              end
            end
            ACT_REVOKE: begin
              if (!found) code <= R_UNKNOWN;
              else if (!hit.attr.active) code <= R_REVOKED;
              else begin
                we <= 1'b1;
                waddr <= IW'(at);
                wdata <= {hit.peer_id, 32'd0, hit.epoch, 1'b0, hit.attr.kind,
                          hit.attr.perms, hit.attr.chan};
                if (live_total != 0) live_total <= live_total - 1'b1;
              end
            end
            default: begin
              if (!found) code <= R_UNKNOWN;
              else if (hit.attr.active) code <= R_STATE;
              else begin
                idx <= at + 1'b1;
                raddr <= IW'(at + 1'b1);
                state <= S_SHRD;
              end
            end
          endcase
        end
        S_SHRD: begin
          if (idx >= entry_count) begin
            entry_count <= entry_count - 1'b1;
            state <= S_DONE;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          we <= 1'b1;
          waddr <= IW'(idx - 1'b1);
          wdata <= rd;
          idx <= idx + 1'b1;
          raddr <= IW'(idx + 1'b1);
          state <= S_SHRD;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.result_code = code;
    rsp.access_ok = granted;
    rsp.approval_open = approval_flag;
    rsp.stored_count = 4'(entry_count);
    rsp.live_count = 4'(live_total);
  end
endmodule
`default_nettype wire

// ----- hdl/peer_authorization_table_top.sv -----
// Peer authorization table, one command word at a time.
// Each word scans every stored entry before the result; a forget that removes an entry
// also shifts each later entry down by one place.
// A new word is taken only while idle; busy is low again in the cycle done strobes.
// The receiver cannot stall; done marks the result for one cycle.
// Synchronous reset empties the table and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module peer_authorization_table_top #(
  parameter int MaxPeers = pat_pkg::MaxPeersDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire pat_pkg::cmd_t cmd,
  output logic done,
  output pat_pkg::rsp_t rsp,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [63:0] cfg_data
);
  import pat_pkg::*;

  logic [63:0] window_length;
  logic [3:0][15:0] kind_masks;
  logic [15:0] valid_perm_mask;

  pat_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .window_length, .kind_masks, .valid_perm_mask
  );

  pat_engine #(.MaxPeers(MaxPeers)) u_engine (
    .clk, .rst, .start, .busy, .cmd,
    .window_length, .kind_masks, .valid_perm_mask,
    .done, .rsp
  );
endmodule
`default_nettype wire
